[sv/stop_and_wait_arq_framer_assert.svh]
// assertion macros used by the port-level checker file
// no dependencies; expects clock and, for SAW_ASSERT, active-low reset names as arguments
`ifndef STOP_AND_WAIT_ARQ_FRAMER_ASSERT_SVH
`define STOP_AND_WAIT_ARQ_FRAMER_ASSERT_SVH

// clocked assertion with asynchronous active-low reset
`define SAW_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// same, without a disable condition
`define SAW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/saw_arq_pkg.sv]
// shared constants, codes and the crc byte step of the arq framer
// no dependencies
`default_nettype none
package saw_arq_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int MAX_FRAME   = 32;
  localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
  localparam int IDX_W       = $clog2(MAX_FRAME);
  localparam int LEN_W       = IDX_W + 1;
  localparam int ADDR_W      = SLOT_W + IDX_W;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int BUILD_MAX   = MAX_FRAME - 6;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] TIMEOUT_RST = 16'd5000;
  localparam logic [3:0]  RETRY_RST   = 4'd5;

  localparam logic [2:0] REQ_PAYLOAD = 3'd0;
  localparam logic [2:0] REQ_FRAME   = 3'd1;
  localparam logic [2:0] REQ_TICK    = 3'd2;
  localparam logic [2:0] REQ_CLOSE   = 3'd3;
  localparam logic [2:0] REQ_CLEAR   = 3'd4;

  localparam logic [2:0] KIND_TX     = 3'd0;
  localparam logic [2:0] KIND_ANS    = 3'd1;
  localparam logic [2:0] KIND_ERR    = 3'd2;
  localparam logic [2:0] KIND_RESENT = 3'd3;
  localparam logic [2:0] KIND_DROP   = 3'd4;

  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_RETRY   = 1'b1;

  // crc-16/modbus over one byte, lsb first
  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[sv/stop_and_wait_arq_framer.sv]
// stop-and-wait arq sender: frame builder, crc walker, send queue, ack check
// depends on saw_arq_pkg
//
// channel   dir  handshake             contents
// s_axis    in   tvalid/tready         tuser req_type, tdata data_byte, tlast last
// m_axis    out  tvalid/tready         tuser kind, tdata byte+queued_frames, tlast
// cfg       in   cfg_we_i              cfg_idx_i register, cfg_data_i value
//
// bytes that do not end a payload or frame leave the sequencer idle; ready stays high
// a payload end holds the input through the header write, the crc walk over the
// frame store read port, the crc write and, if none was awaiting, the transmission
// a received frame end holds the input for crc walk, id check and output bytes
// reset clears state, queue pointers and flags; memories hold garbage until written
// output stalls hold the sequencer; the input is not ready while it works
`default_nettype none
module stop_and_wait_arq_framer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic [2:0]  s_axis_tuser,   // [2:0] req_type
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [7:0] data_byte_res, [11:8] queued_frames
  output logic [2:0]       m_axis_tuser,   // [2:0] kind
  output logic             m_axis_tlast,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);
  import saw_arq_pkg::*;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_HDR     = 4'd1;
  localparam logic [3:0] ST_CRC_RD  = 4'd2;
  localparam logic [3:0] ST_CRC_USE = 4'd3;
  localparam logic [3:0] ST_CRC_WR  = 4'd4;
  localparam logic [3:0] ST_ID_RD   = 4'd5;
  localparam logic [3:0] ST_ID_USE  = 4'd6;
  localparam logic [3:0] ST_ANS_RD  = 4'd7;
  localparam logic [3:0] ST_ANS_OUT = 4'd8;
  localparam logic [3:0] ST_TX_RD   = 4'd9;
  localparam logic [3:0] ST_TX_OUT  = 4'd10;
  localparam logic [3:0] ST_EVT     = 4'd11;

  logic [7:0]        store_mem [QUEUE_DEPTH*MAX_FRAME];
  logic [7:0]        rx_mem    [MAX_FRAME];
  logic [LEN_W-1:0]  lens_q    [QUEUE_DEPTH];

  logic [3:0]        state_q, state_d;
  logic [15:0]       timeout_q;
  logic [3:0]        retry_q;
  logic [SLOT_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]  count_q, count_d, out_cnt_q, out_cnt_d;
  logic [15:0]       next_id_q, next_id_d, tick_q, tick_d, crc_q, crc_d;
  logic              await_q, await_d, ovf_q, ovf_d, blocked_q, blocked_d;
  logic              resend_q, resend_d, ok_q, ok_d, src_rx_q, src_rx_d;
  logic [4:0]        retries_q, retries_d;
  logic [LEN_W-1:0]  rx_len_q, rx_len_d, len_q, len_d, idx_q, idx_d;
  logic [IDX_W-1:0]  build_q, build_d;
  logic [7:0]        id0_q, id0_d, id1_q, id1_d;
  logic [2:0]        evt_q, evt_d;

  logic              m_valid_q;
  logic [2:0]        m_kind_q;
  logic [7:0]        m_byte_q;
  logic              m_last_q;
  logic [CNT_W-1:0]  m_cnt_q;

  logic [7:0]        st_rd_q, rx_rd_q;
  logic              st_we, rx_we, lens_we, out_ld, out_last;
  logic [ADDR_W-1:0] st_waddr, st_raddr;
  logic [7:0]        st_wdata, out_byte, crc_byte;
  logic [2:0]        out_kind;

  logic              acc, out_free, blk, payload_wr, rx_bad;
  logic [IDX_W-1:0]  build_n;
  logic [LEN_W-1:0]  rx_n, crc_end;
  logic [15:0]       tick_n, limit;

  assign acc        = s_axis_tvalid && s_axis_tready;
  assign out_free   = !m_valid_q || m_axis_tready;
  assign blk        = blocked_q || (count_q >= CNT_W'(QUEUE_DEPTH));
  assign payload_wr = !blk && (build_q < IDX_W'(BUILD_MAX));
  assign build_n    = build_q + (payload_wr ? IDX_W'(1) : IDX_W'(0));
  assign rx_n       = (rx_len_q < LEN_W'(MAX_FRAME)) ? rx_len_q + LEN_W'(1) : rx_len_q;
  assign rx_bad     = ovf_q || (rx_len_q >= LEN_W'(MAX_FRAME));
  assign tick_n     = tick_q + 16'd1;
  assign limit      = (timeout_q == 16'd0) ? 16'd1 : timeout_q;
  // rx walk also checks the two crc bytes; store walk stops before them
  assign crc_end    = src_rx_q ? len_q - LEN_W'(1) : len_q - LEN_W'(3);
  assign crc_byte   = src_rx_q ? rx_rd_q : st_rd_q;

  always_comb begin
    case (state_q)
      ST_ID_RD, ST_ID_USE, ST_TX_RD, ST_TX_OUT: st_raddr = {head_q, idx_q[IDX_W-1:0]};
      default:                                  st_raddr = {tail_q, idx_q[IDX_W-1:0]};
    endcase
  end

  always_comb begin
    state_d = state_q;   head_d = head_q;       tail_d = tail_q;
    count_d = count_q;   out_cnt_d = out_cnt_q; next_id_d = next_id_q;
    tick_d = tick_q;     crc_d = crc_q;         await_d = await_q;
    ovf_d = ovf_q;       blocked_d = blocked_q; resend_d = resend_q;
    ok_d = ok_q;         src_rx_d = src_rx_q;   retries_d = retries_q;
    rx_len_d = rx_len_q; len_d = len_q;         idx_d = idx_q;
    build_d = build_q;   id0_d = id0_q;         id1_d = id1_q;
    evt_d = evt_q;
    st_we = 1'b0; st_waddr = {tail_q, IDX_W'(4) + build_q}; st_wdata = s_axis_tdata;
    rx_we = 1'b0; lens_we = 1'b0;
    out_ld = 1'b0; out_kind = KIND_TX; out_byte = 8'h00; out_last = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          case (s_axis_tuser)
            REQ_PAYLOAD: begin
              st_we     = payload_wr;
              build_d   = build_n;
              blocked_d = blk;
              if (s_axis_tlast) begin
                build_d   = '0;
                blocked_d = 1'b0;
                if (blk) begin
                  evt_d     = KIND_DROP;
                  out_cnt_d = count_q;
                  state_d   = ST_EVT;
                end else begin
                  len_d   = LEN_W'(build_n) + LEN_W'(6);
                  idx_d   = '0;
                  state_d = ST_HDR;
                end
              end
            end
            REQ_FRAME: begin
              rx_we    = !rx_bad;
              rx_len_d = rx_n;
              ovf_d    = rx_bad;
              if (s_axis_tlast) begin
                rx_len_d = '0;
                ovf_d    = 1'b0;
                if (!rx_bad && rx_n >= LEN_W'(6) && await_q && count_q != '0) begin
                  len_d    = rx_n;
                  idx_d    = '0;
                  crc_d    = CRC_INIT;
                  ok_d     = 1'b1;
                  src_rx_d = 1'b1;
                  state_d  = ST_CRC_RD;
                end
              end
            end
            REQ_TICK: begin
              if (await_q) begin
                if (tick_n < limit) begin
                  tick_d = tick_n;
                end else begin
                  tick_d    = '0;
                  out_cnt_d = count_q;
                  if (retries_q > {1'b0, retry_q} || count_q == '0) begin
                    await_d   = 1'b0;
                    retries_d = '0;
                    evt_d     = KIND_ERR;
                    state_d   = ST_EVT;
                  end else begin
                    retries_d = retries_q + 5'd1;
                    resend_d  = 1'b1;
                    idx_d     = '0;
                    state_d   = ST_TX_RD;
                  end
                end
              end
            end
            REQ_CLOSE: begin
              await_d = 1'b0; retries_d = '0; tick_d = '0;
            end
            REQ_CLEAR: begin
              head_d = '0; tail_d = '0; count_d = '0;
              build_d = '0; blocked_d = 1'b0;
              await_d = 1'b0; retries_d = '0; tick_d = '0;
            end
            default: ;
          endcase
        end
      end
      ST_HDR: begin
        st_we    = 1'b1;
        st_waddr = {tail_q, idx_q[IDX_W-1:0]};
        case (idx_q[1:0])
          2'd0:    st_wdata = next_id_q[7:0];
          2'd1:    st_wdata = next_id_q[15:8];
          2'd2:    st_wdata = 8'(len_q);
          default: st_wdata = 8'h00;
        endcase
        idx_d = idx_q + LEN_W'(1);
        if (idx_q == LEN_W'(3)) begin
          idx_d    = '0;
          crc_d    = CRC_INIT;
          src_rx_d = 1'b0;
          state_d  = ST_CRC_RD;
        end
      end
      ST_CRC_RD: state_d = ST_CRC_USE;
      ST_CRC_USE: begin
        if (idx_q < len_q - LEN_W'(2)) begin
          crc_d = crc_step(crc_q, crc_byte);
          if (idx_q == LEN_W'(0)) id0_d = crc_byte;
          if (idx_q == LEN_W'(1)) id1_d = crc_byte;
        end else if (crc_byte != ((idx_q == len_q - LEN_W'(2)) ? crc_q[7:0] : crc_q[15:8])) begin
          ok_d = 1'b0;
        end
        idx_d   = idx_q + LEN_W'(1);
        state_d = ST_CRC_RD;
        if (idx_q == crc_end) begin
          idx_d = '0;
          if (!src_rx_q)  state_d = ST_CRC_WR;
          else if (ok_d)  state_d = ST_ID_RD;
          else            state_d = ST_IDLE;
        end
      end
      ST_CRC_WR: begin
        st_we    = 1'b1;
        st_waddr = {tail_q, IDX_W'(len_q - LEN_W'(2) + idx_q)};
        st_wdata = idx_q[0] ? crc_q[15:8] : crc_q[7:0];
        idx_d    = LEN_W'(1);
        if (idx_q[0]) begin
          lens_we   = 1'b1;
          next_id_d = next_id_q + 16'd1;
          tail_d    = tail_q + SLOT_W'(1);
          count_d   = count_q + CNT_W'(1);
          state_d   = ST_IDLE;
          if (!await_q) begin
            await_d   = 1'b1;
            tick_d    = '0;
            out_cnt_d = count_q + CNT_W'(1);
            resend_d  = 1'b0;
            idx_d     = '0;
            state_d   = ST_TX_RD;
          end
        end
      end
      ST_ID_RD: state_d = ST_ID_USE;
      ST_ID_USE: begin
        if (st_rd_q != (idx_q[0] ? id1_q : id0_q)) begin
          state_d = ST_IDLE;
        end else if (idx_q[0]) begin
          retries_d = '0;
          tick_d    = '0;
          head_d    = head_q + SLOT_W'(1);
          count_d   = count_q - CNT_W'(1);
          out_cnt_d = count_q - CNT_W'(1);
          if (len_q > LEN_W'(6)) begin
            idx_d   = LEN_W'(4);
            state_d = ST_ANS_RD;
          end else if (count_q != CNT_W'(1)) begin
            resend_d = 1'b0;
            idx_d    = '0;
            state_d  = ST_TX_RD;
          end else begin
            await_d = 1'b0;
            state_d = ST_IDLE;
          end
        end else begin
          idx_d   = LEN_W'(1);
          state_d = ST_ID_RD;
        end
      end
      ST_ANS_RD: state_d = ST_ANS_OUT;
      ST_ANS_OUT: begin
        if (out_free) begin
          out_ld   = 1'b1;
          out_kind = KIND_ANS;
          out_byte = rx_rd_q;
          out_last = (idx_q == len_q - LEN_W'(3));
          idx_d    = idx_q + LEN_W'(1);
          state_d  = ST_ANS_RD;
          if (out_last) begin
            if (count_q != '0) begin
              resend_d = 1'b0;
              idx_d    = '0;
              state_d  = ST_TX_RD;
            end else begin
              await_d = 1'b0;
              state_d = ST_IDLE;
            end
          end
        end
      end
      ST_TX_RD: state_d = ST_TX_OUT;
      ST_TX_OUT: begin
        if (out_free) begin
          out_ld   = 1'b1;
          out_kind = KIND_TX;
          out_byte = st_rd_q;
          out_last = (idx_q == lens_q[head_q] - LEN_W'(1));
          idx_d    = idx_q + LEN_W'(1);
          state_d  = ST_TX_RD;
          if (out_last) begin
            evt_d   = KIND_RESENT;
            state_d = resend_q ? ST_EVT : ST_IDLE;
          end
        end
      end
      ST_EVT: begin
        if (out_free) begin
          out_ld   = 1'b1;
          out_kind = evt_q;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);

  // frame store and receive buffer, registered reads
  always_ff @(posedge clk_i) begin
    if (st_we) store_mem[st_waddr] <= st_wdata;
    st_rd_q <= store_mem[st_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rx_we) rx_mem[rx_len_q[IDX_W-1:0]] <= s_axis_tdata;
    rx_rd_q <= rx_mem[idx_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (lens_we) lens_q[tail_q] <= len_q;
  end

  always_ff @(posedge clk_i) begin
    crc_q <= crc_d; len_q <= len_d; idx_q <= idx_d;
    id0_q <= id0_d; id1_q <= id1_d; evt_q <= evt_d;
    if (out_ld) begin
      m_kind_q <= out_kind;
      m_byte_q <= out_byte;
      m_last_q <= out_last;
      m_cnt_q  <= out_cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      timeout_q <= TIMEOUT_RST;
      retry_q   <= RETRY_RST;
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      out_cnt_q <= '0;
      next_id_q <= '0;
      tick_q    <= '0;
      await_q   <= 1'b0;
      ovf_q     <= 1'b0;
      blocked_q <= 1'b0;
      resend_q  <= 1'b0;
      ok_q      <= 1'b0;
      src_rx_q  <= 1'b0;
      retries_q <= '0;
      rx_len_q  <= '0;
      build_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      out_cnt_q <= out_cnt_d;
      next_id_q <= next_id_d;
      tick_q    <= tick_d;
      await_q   <= await_d;
      ovf_q     <= ovf_d;
      blocked_q <= blocked_d;
      resend_q  <= resend_d;
      ok_q      <= ok_d;
      src_rx_q  <= src_rx_d;
      retries_q <= retries_d;
      rx_len_q  <= rx_len_d;
      build_q   <= build_d;
      if (out_ld)             m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_TIMEOUT) timeout_q <= cfg_data_i;
        if (cfg_idx_i == CFG_RETRY)   retry_q   <= cfg_data_i[3:0];
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_kind_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tdata  = {{(8 - CNT_W){1'b0}}, m_cnt_q, m_byte_q};

endmodule
`default_nettype wire

[sv/saw_arq_chk.sv]
// port-level checker for the arq framer, bound to the top level
// depends on saw_arq_pkg and stop_and_wait_arq_framer_assert.svh
`default_nettype none
`include "stop_and_wait_arq_framer_assert.svh"
module saw_arq_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);
  import saw_arq_pkg::*;

  `SAW_ASSERT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")
  `SAW_ASSERT(a_kind, clk_i, rst_ni, m_axis_tvalid |-> m_axis_tuser <= KIND_DROP, "unknown result kind")
  `SAW_ASSERT(a_evt, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser == KIND_ERR || m_axis_tuser == KIND_RESENT || m_axis_tuser == KIND_DROP) |-> m_axis_tlast && m_axis_tdata[7:0] == 8'h00, "event result carries data")
  `SAW_ASSERT(a_cnt, clk_i, rst_ni, m_axis_tvalid |-> m_axis_tdata[15:8] <= 8'(QUEUE_DEPTH), "queue count out of range")

endmodule

bind stop_and_wait_arq_framer saw_arq_chk u_saw_arq_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

[tb/sv/saw_arq_checker.sv]
// result checker for the arq framer: mirrors requests and config writes,
// predicts transmit, answer and status results, compares them in order
// depends on saw_arq_pkg
`default_nettype none
module saw_arq_checker
  import saw_arq_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  input  wire logic        s_tready_i,
  input  wire logic [7:0]  s_tdata_i,
  input  wire logic [2:0]  s_tuser_i,
  input  wire logic        s_tlast_i,
  input  wire logic        m_tvalid_i,
  input  wire logic        m_tready_i,
  input  wire logic [15:0] m_tdata_i,
  input  wire logic [2:0]  m_tuser_i,
  input  wire logic        m_tlast_i,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  output int               fail_count_o,
  output int               pending_o,
  output logic             waiting_o,
  output logic [15:0]      head_id_o
);

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       last;
    logic [3:0] queued;
  } arq_result_t;

  arq_result_t due_q[$];
  arq_result_t step_q[$];
  int          fails;

  logic [15:0] tmo_ticks;
  logic [3:0]  retry_max;
  logic [7:0]  fstore[QUEUE_DEPTH*MAX_FRAME];
  int          flen[QUEUE_DEPTH];
  int          head, tail, qcnt;
  logic [15:0] next_id;
  logic        waiting;
  int          retries;
  logic [15:0] ticks;
  logic [7:0]  rxbuf[MAX_FRAME];
  int          rxlen;
  logic        rxovf;
  int          blen;
  logic        blocked;

  function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
    return r;
  endfunction

  task automatic add_result(input logic [2:0] kind, input logic [7:0] data, input logic last);
    if (step_q.size() < 64) step_q.push_back('{kind, data, last, 4'd0});
  endtask

  task automatic transmit_head();
    for (int i = 0; i < flen[head]; i++)
      add_result(KIND_TX, fstore[head*MAX_FRAME + i], i + 1 == flen[head]);
  endtask

  task automatic stop_waiting();
    waiting = 1'b0;
    retries = 0;
    ticks   = '0;
  endtask

  task automatic take_payload(input logic [7:0] b, input logic l);
    int          base;
    int          len;
    logic [15:0] c;
    if (qcnt >= QUEUE_DEPTH) blocked = 1'b1;
    if (!blocked && blen < BUILD_MAX) begin
      fstore[tail*MAX_FRAME + 4 + blen] = b;
      blen++;
    end
    if (!l) return;
    if (blocked || qcnt >= QUEUE_DEPTH) begin
      add_result(KIND_DROP, 8'h00, 1'b1);
    end else begin
      base = tail * MAX_FRAME;
      len  = blen + 6;
      fstore[base]   = next_id[7:0];
      fstore[base+1] = next_id[15:8];
      fstore[base+2] = 8'(len);
      fstore[base+3] = 8'h00;
      c = 16'hFFFF;
      for (int i = 0; i < len - 2; i++) c = crc_next(c, fstore[base + i]);
      fstore[base+len-2] = c[7:0];
      fstore[base+len-1] = c[15:8];
      flen[tail] = len;
      next_id++;
      tail = (tail + 1) % QUEUE_DEPTH;
      qcnt++;
      if (!waiting) begin
        waiting = 1'b1;
        ticks   = '0;
        transmit_head();
      end
    end
    blen    = 0;
    blocked = 1'b0;
  endtask

  task automatic take_frame_byte(input logic [7:0] b, input logic l);
    int          len;
    logic        bad;
    logic [15:0] c;
    if (rxlen < MAX_FRAME) begin
      rxbuf[rxlen] = b;
      rxlen++;
    end else begin
      rxovf = 1'b1;
    end
    if (!l) return;
    len   = rxlen;
    bad   = rxovf;
    rxlen = 0;
    rxovf = 1'b0;
    if (bad || len < 6 || !waiting || qcnt == 0) return;
    c = 16'hFFFF;
    for (int i = 0; i < len - 2; i++) c = crc_next(c, rxbuf[i]);
    if (rxbuf[len-2] != c[7:0] || rxbuf[len-1] != c[15:8]) return;
    if (rxbuf[0] != fstore[head*MAX_FRAME] || rxbuf[1] != fstore[head*MAX_FRAME+1]) return;
    retries = 0;
    ticks   = '0;
    for (int i = 4; i < len - 2; i++) add_result(KIND_ANS, rxbuf[i], i + 1 == len - 2);
    head = (head + 1) % QUEUE_DEPTH;
    qcnt--;
    if (qcnt > 0) begin
      waiting = 1'b1;
      transmit_head();
    end else begin
      waiting = 1'b0;
    end
  endtask

  task automatic take_tick();
    logic [15:0] limit;
    if (!waiting) return;
    limit = (tmo_ticks != 0) ? tmo_ticks : 16'd1;
    ticks++;
    if (ticks < limit) return;
    ticks = '0;
    if (retries > retry_max || qcnt == 0) begin
      stop_waiting();
      add_result(KIND_ERR, 8'h00, 1'b1);
    end else begin
      transmit_head();
      add_result(KIND_RESENT, 8'h00, 1'b1);
      retries++;
    end
  endtask

  task automatic arq_model_step(input logic [2:0] req, input logic [7:0] b, input logic l);
    arq_result_t r;
    step_q.delete();
    case (req)
      REQ_PAYLOAD: take_payload(b, l);
      REQ_FRAME:   take_frame_byte(b, l);
      REQ_TICK:    take_tick();
      REQ_CLOSE:   stop_waiting();
      REQ_CLEAR: begin
        head = 0; tail = 0; qcnt = 0;
        blen = 0; blocked = 1'b0;
        stop_waiting();
      end
      default: ;
    endcase
    foreach (step_q[k]) begin
      r = step_q[k];
      r.queued = 4'(qcnt);
      due_q.push_back(r);
    end
  endtask

  task automatic model_reset();
    tmo_ticks = TIMEOUT_RST;
    retry_max = RETRY_RST;
    foreach (fstore[i]) fstore[i] = 8'h00;
    foreach (flen[i]) flen[i] = 0;
    foreach (rxbuf[i]) rxbuf[i] = 8'h00;
    head = 0; tail = 0; qcnt = 0;
    next_id = '0;
    stop_waiting();
    rxlen = 0; rxovf = 1'b0;
    blen = 0; blocked = 1'b0;
  endtask

  initial begin
    fails = 0;
    model_reset();
  end

  always @(posedge clk_i or negedge rst_ni) begin
    arq_result_t e;
    if (!rst_ni) begin
      model_reset();
      due_q.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (due_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none, actual kind=%0d data=%02h last=%0d",
                   $time, m_tuser_i, m_tdata_i[7:0], m_tlast_i);
        end else begin
          e = due_q.pop_front();
          if (m_tuser_i !== e.kind || m_tdata_i[7:0] !== e.data || m_tlast_i !== e.last ||
              m_tdata_i[11:8] !== e.queued) begin
            fails++;
            $display("%0t: mismatch expected kind=%0d data=%02h last=%0d queued=%0d",
                     $time, e.kind, e.data, e.last, e.queued);
            $display("%0t:          actual   kind=%0d data=%02h last=%0d queued=%0d",
                     $time, m_tuser_i, m_tdata_i[7:0], m_tlast_i, m_tdata_i[11:8]);
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_TIMEOUT) tmo_ticks = cfg_data_i;
        else retry_max = cfg_data_i[3:0];
      end
      if (s_tvalid_i && s_tready_i) arq_model_step(s_tuser_i, s_tdata_i, s_tlast_i);
    end
    fail_count_o <= fails;
    pending_o    <= due_q.size();
    waiting_o    <= waiting && qcnt > 0;
    head_id_o    <= {fstore[head*MAX_FRAME+1], fstore[head*MAX_FRAME]};
  end

endmodule
`default_nettype wire

[tb/sv/tb.sv]
// testbench top for the arq framer: clock, reset, request and config stimulus,
// receiver backpressure and the verdict; depends on saw_arq_pkg and saw_arq_checker
`default_nettype none
module tb;
  import saw_arq_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [15:0] cfg_data_i = '0;

  int          fail_count;
  int          pending;
  logic        waiting;
  logic [15:0] head_id;
  logic        calm = 1'b0;
  logic        stall_req = 1'b0;
  logic        stall_done = 1'b0;
  int          hold = 0;
  int          items = 0;

  always #6 clk_i = ~clk_i;

  stop_and_wait_arq_framer dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  saw_arq_checker chk (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready), .s_tdata_i(s_axis_tdata),
    .s_tuser_i(s_axis_tuser), .s_tlast_i(s_axis_tlast),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready), .m_tdata_i(m_axis_tdata),
    .m_tuser_i(m_axis_tuser), .m_tlast_i(m_axis_tlast),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending), .waiting_o(waiting), .head_id_o(head_id)
  );

  // receiver: random backpressure, one long hold-off on request
  always @(posedge clk_i) begin
    if (stall_req && !stall_done) begin
      stall_done    <= 1'b1;
      hold          <= 900;
      m_axis_tready <= 1'b0;
    end else if (hold > 0) begin
      hold          <= hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 17);
    end
  end

  function automatic logic [15:0] modbus16(input logic [7:0] bytes[$], input int n);
    logic [15:0] c;
    c = 16'hFFFF;
    for (int i = 0; i < n; i++) begin
      c = c ^ {8'h00, bytes[i]};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  task automatic send_item(input logic [2:0] req, input logic [7:0] b, input logic l);
    if (!calm && $urandom_range(99) < 17) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= b;
    s_axis_tlast  <= l;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items++;
  endtask

  task automatic send_payload(input int n, input int fill);
    for (int i = 0; i < n; i++)
      send_item(REQ_PAYLOAD, (fill < 0) ? 8'($urandom) : 8'(fill), i == n - 1);
  endtask

  task automatic send_bytes(input logic [7:0] bytes[$]);
    foreach (bytes[i]) send_item(REQ_FRAME, bytes[i], i == bytes.size() - 1);
  endtask

  // flaw: 0 good, 1 bad crc, 2 wrong id, 3 short, 4 overflow
  task automatic send_ack(input int n, input int flaw);
    logic [7:0]  f[$];
    logic [15:0] c;
    logic [15:0] id;
    // let the checker publish the current head before reading it
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    id = head_id;
    if (flaw == 2) id = id ^ 16'(1 << $urandom_range(15));
    if (flaw == 3) begin
      repeat ($urandom_range(1, 5)) f.push_back(8'($urandom));
    end else if (flaw == 4) begin
      repeat ($urandom_range(33, 36)) f.push_back(8'($urandom));
    end else begin
      f.push_back(id[7:0]);
      f.push_back(id[15:8]);
      f.push_back(8'(n + 6));
      f.push_back(8'h00);
      repeat (n) f.push_back(8'($urandom));
      c = modbus16(f, f.size());
      if (flaw == 1) c = c ^ 16'(1 << $urandom_range(15));
      f.push_back(c[7:0]);
      f.push_back(c[15:8]);
    end
    send_bytes(f);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_phase(input int count, input int short_frames);
    int r;
    int stop_at;
    stop_at = items + count;
    while (items < stop_at) begin
      r = $urandom_range(99);
      if (r < 32) begin
        send_payload(($urandom_range(9) == 0) ? $urandom_range(7, 30)
                                                : $urandom_range(1, short_frames), -1);
      end else if (r < 55) begin
        if (waiting) send_ack($urandom_range(0, 4), 0);
        else send_item(REQ_TICK, 8'($urandom), 1'($urandom));
      end else if (r < 65) begin
        send_ack($urandom_range(0, 3), $urandom_range(1, 4));
      end else if (r < 87) begin
        send_item(REQ_TICK, 8'($urandom), 1'($urandom));
      end else if (r < 90) begin
        send_item(REQ_CLOSE, 8'($urandom), 1'($urandom));
      end else if (r < 92) begin
        send_item(REQ_CLEAR, 8'($urandom), 1'($urandom));
      end else if (r < 95) begin
        send_item(3'($urandom_range(5, 7)), 8'($urandom), 1'($urandom));
      end else begin
        send_item(REQ_FRAME, 8'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(CFG_TIMEOUT, 16'd2);
    write_reg(CFG_RETRY, 16'd1);

    // directed part
    send_item(REQ_TICK, 8'h00, 1'b0);        // idle tick is ignored
    send_payload(1, 8'h00);
    send_ack(2, 1);
    send_ack(2, 2);
    send_ack(3, 0);
    send_payload(30, 8'hFF);                 // truncated to the longest payload
    send_ack(0, 0);                          // empty answer
    send_ack(0, 3);
    send_ack(1, 0);                          // nothing pending
    send_payload(2, -1);
    repeat (6) send_item(REQ_TICK, 8'hFF, 1'b1);   // two resends, then an error
    send_item(REQ_CLOSE, 8'h00, 1'b0);
    send_payload(1, -1);                     // old head goes out again
    send_ack(0, 4);
    send_ack(1, 0);
    send_item(3'd5, 8'h5A, 1'b0);
    send_item(3'd6, 8'hA5, 1'b1);
    send_item(3'd7, 8'hFF, 1'b1);
    send_item(REQ_CLEAR, 8'h00, 1'b0);
    repeat (9) send_payload(1, -1);          // last one meets a full queue
    send_item(REQ_CLEAR, 8'h00, 1'b1);
    drain();

    write_reg(CFG_TIMEOUT, 16'hFFFF);
    write_reg(CFG_RETRY, 16'd15);
    calm = 1'b1;
    random_phase(40, 4);
    calm = 1'b0;
    // long receiver hold-off while the sender keeps queuing frames
    stall_req <= 1'b1;
    repeat (12) send_payload($urandom_range(1, 3), -1);
    drain();

    write_reg(CFG_TIMEOUT, 16'd1);
    write_reg(CFG_RETRY, 16'd0);
    random_phase(60, 5);
    drain();

    write_reg(CFG_TIMEOUT, 16'($urandom_range(2, 6)));
    write_reg(CFG_RETRY, 16'($urandom_range(1, 4)));
    random_phase(60, 6);
    drain();

    write_reg(CFG_TIMEOUT, 16'($urandom_range(3, 9)));
    write_reg(CFG_RETRY, 16'($urandom_range(0, 15)));
    random_phase(60, 8);
    drain();

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #30000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
`default_nettype wire
